@@ design/sqpe_pkg.sv @@
// ----------------------------------------------------------------------------
// Superquadric point evaluator package
// Shared types, constants and elaboration-time functions.
// ----------------------------------------------------------------------------
package sqpe_pkg;

    localparam int CORDIC_ITERS = 24;
    localparam int POW_BITS     = 16;
    localparam int POW_LAT      = 37;

    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

    localparam logic [29:0] ATAN_TURNS [CORDIC_ITERS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    typedef enum logic [1:0] {
        CFG_RADIUS  = 2'd0,
        CFG_EXP_LAT = 2'd1,
        CFG_EXP_LON = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic        neg;
        logic [30:0] mag;
    } spow_t;

    function automatic logic [63:0] sqpe_isqrt(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = n;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Q1.30 value of 2^(2^-k).
    function automatic logic [30:0] sqpe_root(input int k);
        logic [63:0] c;
        c = sqpe_isqrt(64'h2000_0000_0000_0000);
        for (int j = 2; j <= k; j++)
        begin
            c = sqpe_isqrt(c << 30);
        end
        return c[30:0];
    endfunction

endpackage

@@ design/sqpe_if.sv @@
// ----------------------------------------------------------------------------
// Superquadric point evaluator channels
// Valid/ready channels for parametric points and for vertex coordinates.
// ----------------------------------------------------------------------------
interface sqpe_in_if;
    logic        valid;
    logic        ready;
    logic [16:0] u_param;
    logic [16:0] v_param;
    modport source (output valid, output u_param, output v_param, input ready);
    modport sink (input valid, input u_param, input v_param, output ready);
endinterface

interface sqpe_out_if;
    logic               valid;
    logic               ready;
    logic signed [25:0] x_coord;
    logic signed [25:0] y_coord;
    logic signed [25:0] z_coord;
    modport source (output valid, output x_coord, output y_coord, output z_coord,
                    input ready);
    modport sink (input valid, input x_coord, input y_coord, input z_coord,
                  output ready);
endinterface

@@ design/sqpe_cordic.sv @@
// ----------------------------------------------------------------------------
// Superquadric point evaluator CORDIC
// Two-lane pipelined sine and cosine of Q0.17-turn phases, Q1.16 results.
// ----------------------------------------------------------------------------
module sqpe_cordic
    import sqpe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [16:0]        phase_a,
    input  logic [16:0]        phase_b,
    output logic               out_valid,
    output logic signed [17:0] ca,
    output logic signed [17:0] sa,
    output logic signed [17:0] cb,
    output logic signed [17:0] sb
);

    logic [CORDIC_ITERS+1:0] valid_reg;
    logic [16:0]             ph [2];
    logic signed [17:0]      cs_out [2];
    logic signed [17:0]      sn_out [2];

    assign ph[0] = phase_a;
    assign ph[1] = phase_b;
    assign ca = cs_out[0];
    assign sa = sn_out[0];
    assign cb = cs_out[1];
    assign sb = sn_out[1];
    assign out_valid = valid_reg[CORDIC_ITERS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[CORDIC_ITERS:0], in_valid};
        end
    end

    function automatic logic signed [17:0] clamp_unit(input logic signed [33:0] v);
        logic signed [33:0] r;
        r = (v + 34'sd8192) >>> 14;
        if (r > 34'sd65536)
            return 18'sd65536;
        else if (r < -34'sd65536)
            return -18'sd65536;
        else
            return r[17:0];
    endfunction

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic signed [33:0] x_reg [CORDIC_ITERS+1];
        logic signed [33:0] y_reg [CORDIC_ITERS+1];
        logic signed [31:0] z_reg [CORDIC_ITERS+1];
        logic [1:0]         q_reg [CORDIC_ITERS+1];
        logic signed [17:0] cs_reg;
        logic signed [17:0] sn_reg;
        logic signed [17:0] xc;
        logic signed [17:0] yc;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[0] <= CORDIC_K;
                y_reg[0] <= '0;
                z_reg[0] <= {2'b00, ph[l][14:0], 15'b0};
                q_reg[0] <= ph[l][16:15];
            end
        end

        for (genvar i = 0; i < CORDIC_ITERS; i++)
        begin : g_iter
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!z_reg[i][31])
                    begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] - $signed({2'b00, ATAN_TURNS[i]});
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] + $signed({2'b00, ATAN_TURNS[i]});
                    end
                    q_reg[i+1] <= q_reg[i];
                end
            end
        end

        assign xc = clamp_unit(x_reg[CORDIC_ITERS]);
        assign yc = clamp_unit(y_reg[CORDIC_ITERS]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                case (q_reg[CORDIC_ITERS])
                    2'd0:
                    begin
                        cs_reg <= xc;
                        sn_reg <= yc;
                    end
                    2'd1:
                    begin
                        cs_reg <= -yc;
                        sn_reg <= xc;
                    end
                    2'd2:
                    begin
                        cs_reg <= -xc;
                        sn_reg <= -yc;
                    end
                    default:
                    begin
                        cs_reg <= yc;
                        sn_reg <= -xc;
                    end
                endcase
            end
        end

        assign cs_out[l] = cs_reg;
        assign sn_out[l] = sn_reg;
    end

endmodule

@@ design/sqpe_pow.sv @@
// ----------------------------------------------------------------------------
// Superquadric point evaluator power unit
// Pipelined sign-preserving power of a Q1.16 base by a Q4.12 exponent.
// ----------------------------------------------------------------------------
module sqpe_pow
    import sqpe_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [17:0] t,
    input  logic [15:0]        s,
    output spow_t              res
);

    logic [1:0]  flag_reg [POW_LAT-1];
    logic [30:0] m_reg [POW_BITS+1];
    logic [15:0] f_reg [POW_BITS+1];
    logic [4:0]  np_reg [POW_BITS+1];
    logic [20:0] nlog_reg;
    logic [36:0] e_reg;
    logic [30:0] mant_reg [POW_BITS+1];
    logic [15:0] rb_reg [POW_BITS+1];
    logic [9:0]  sh_reg [POW_BITS+1];
    spow_t       res_reg;

    logic signed [17:0] neg_t;
    logic [16:0]        a;
    logic [4:0]         p;
    logic [47:0]        norm;
    logic [28:0]        rem;

    assign neg_t = -t;
    assign a = t[17] ? neg_t[16:0] : t[16:0];

    always_comb
    begin
        p = '0;
        for (int j = 1; j < 17; j++)
        begin
            if (a[j])
                p = 5'(j);
        end
    end

    assign norm = {31'b0, a} << (5'd30 - p);
    assign rem  = 29'h1000_0000 - {1'b0, e_reg[27:0]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flag_reg[0] <= {t == '0, t[17]};
            for (int j = 1; j < POW_LAT - 1; j++)
                flag_reg[j] <= flag_reg[j-1];
            m_reg[0]  <= norm[30:0];
            f_reg[0]  <= '0;
            np_reg[0] <= 5'd16 - p;
            nlog_reg  <= {np_reg[POW_BITS], 16'b0} - {5'b0, f_reg[POW_BITS]};
            e_reg     <= 37'(s * nlog_reg);
            mant_reg[0] <= 31'h4000_0000;
            rb_reg[0]   <= rem[27:12];
            sh_reg[0]   <= {1'b0, e_reg[36:28]} + {9'b0, |e_reg[27:0]};
        end
    end

    for (genvar k = 0; k < POW_BITS; k++)
    begin : g_log
        logic [61:0] sq;
        assign sq = m_reg[k] * m_reg[k];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                np_reg[k+1] <= np_reg[k];
                if (sq[61])
                begin
                    m_reg[k+1] <= sq[61:31];
                    f_reg[k+1] <= {f_reg[k][14:0], 1'b1};
                end
                else
                begin
                    m_reg[k+1] <= sq[60:30];
                    f_reg[k+1] <= {f_reg[k][14:0], 1'b0};
                end
            end
        end
    end

    for (genvar k = 1; k <= POW_BITS; k++)
    begin : g_exp
        localparam logic [30:0] CK = sqpe_root(k);
        logic [61:0] prod;
        assign prod = mant_reg[k-1] * CK;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mant_reg[k] <= rb_reg[k-1][POW_BITS-k] ? prod[60:30] : mant_reg[k-1];
                rb_reg[k]   <= rb_reg[k-1];
                sh_reg[k]   <= sh_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.neg <= flag_reg[POW_LAT-2][0];
            if (flag_reg[POW_LAT-2][1] || sh_reg[POW_BITS] > 10'd30)
                res_reg.mag <= '0;
            else
                res_reg.mag <= mant_reg[POW_BITS] >> sh_reg[POW_BITS][4:0];
        end
    end

    assign res = res_reg;

endmodule

@@ design/sqpe_scale.sv @@
// ----------------------------------------------------------------------------
// Superquadric point evaluator output scaling
// Forms the power products and applies the radius, four register stages.
// ----------------------------------------------------------------------------
module sqpe_scale
    import sqpe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  spow_t              pca,
    input  spow_t              psa,
    input  spow_t              pcb,
    input  spow_t              psb,
    input  logic [15:0]        radius,
    output logic               out_valid,
    output logic signed [25:0] x_coord,
    output logic signed [25:0] y_coord,
    output logic signed [25:0] z_coord
);

    logic [3:0]  valid_reg;
    logic [61:0] px_reg, pz_reg;
    logic [30:0] rx_reg, rz_reg;
    logic [46:0] qx_reg, qy_reg, qz_reg;
    logic [2:0]  s1_reg, s2_reg, s3_reg;
    logic [30:0] ya1_reg, ya2_reg;
    logic signed [25:0] x_reg, y_reg, z_reg;

    logic [61:0] rxs, rzs;
    logic [46:0] mx, my, mz;

    assign rxs = px_reg + 62'h2000_0000;
    assign rzs = pz_reg + 62'h2000_0000;
    assign mx  = qx_reg + 47'h20_0000;
    assign my  = qy_reg + 47'h20_0000;
    assign mz  = qz_reg + 47'h20_0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg  <= pca.mag * pcb.mag;
            pz_reg  <= pca.mag * psb.mag;
            s1_reg  <= {pca.neg ^ pcb.neg, psa.neg, pca.neg ^ psb.neg};
            ya1_reg <= psa.mag;
            rx_reg  <= rxs[60:30];
            rz_reg  <= rzs[60:30];
            ya2_reg <= ya1_reg;
            s2_reg  <= s1_reg;
            qx_reg  <= radius * rx_reg;
            qy_reg  <= radius * ya2_reg;
            qz_reg  <= radius * rz_reg;
            s3_reg  <= s2_reg;
            x_reg   <= s3_reg[2] ? -$signed({1'b0, mx[46:22]}) : $signed({1'b0, mx[46:22]});
            y_reg   <= s3_reg[1] ? -$signed({1'b0, my[46:22]}) : $signed({1'b0, my[46:22]});
            z_reg   <= s3_reg[0] ? -$signed({1'b0, mz[46:22]}) : $signed({1'b0, mz[46:22]});
        end
    end

    assign out_valid = valid_reg[3];
    assign x_coord   = x_reg;
    assign y_coord   = y_reg;
    assign z_coord   = z_reg;

endmodule

@@ design/superquadric_point_eval.sv @@
// ----------------------------------------------------------------------------
// Superquadric point evaluator
// Maps a parametric point (u,v) to a superquadric ellipsoid vertex.
// ----------------------------------------------------------------------------
// One point is accepted every cycle unless the vertex side stalls; it passes
// through 26 stages for the dual CORDIC, 37 for the power units (16 squaring
// steps for the logarithm and 16 constant products for the exponential) and
// 4 for the output products and radius scaling. A stall at the vertex side
// holds the whole pipeline, and the point side is ready whenever the vertex
// register is empty or being taken.
module superquadric_point_eval
    import sqpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sqpe_in_if.sink     point,
    sqpe_out_if.source  vertex,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] radius_reg, exp_lat_reg, exp_lon_reg;
    logic        en;
    logic [16:0] phase_a, phase_b;
    logic        cor_valid;
    logic signed [17:0] ca, sa, cb, sb;
    spow_t       pca, psa, pcb, psb;
    logic [POW_LAT-1:0] pv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= 16'd256;
            exp_lat_reg <= 16'd4096;
            exp_lon_reg <= 16'd4096;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_RADIUS:  radius_reg  <= cfg_data;
                CFG_EXP_LAT: exp_lat_reg <= cfg_data;
                CFG_EXP_LON: exp_lon_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign en          = !vertex.valid || vertex.ready;
    assign point.ready = en;
    assign phase_b     = {point.u_param[15:0], 1'b0};
    assign phase_a     = 17'd32768 - point.v_param;

    sqpe_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (point.valid),
        .phase_a   (phase_a),
        .phase_b   (phase_b),
        .out_valid (cor_valid),
        .ca        (ca),
        .sa        (sa),
        .cb        (cb),
        .sb        (sb)
    );

    sqpe_pow u_pow_ca (.clk(clk), .en(en), .t(ca), .s(exp_lat_reg), .res(pca));
    sqpe_pow u_pow_sa (.clk(clk), .en(en), .t(sa), .s(exp_lat_reg), .res(psa));
    sqpe_pow u_pow_cb (.clk(clk), .en(en), .t(cb), .s(exp_lon_reg), .res(pcb));
    sqpe_pow u_pow_sb (.clk(clk), .en(en), .t(sb), .s(exp_lon_reg), .res(psb));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= '0;
        else if (en)
            pv_reg <= {pv_reg[POW_LAT-2:0], cor_valid};
    end

    sqpe_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pv_reg[POW_LAT-1]),
        .pca       (pca),
        .psa       (psa),
        .pcb       (pcb),
        .psb       (psb),
        .radius    (radius_reg),
        .out_valid (vertex.valid),
        .x_coord   (vertex.x_coord),
        .y_coord   (vertex.y_coord),
        .z_coord   (vertex.z_coord)
    );

endmodule

@@ design/sqpe_checker.sv @@
// ----------------------------------------------------------------------------
// Superquadric point evaluator checker
// Port-level properties of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module sqpe_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [25:0] x_coord,
    input logic signed [25:0] y_coord,
    input logic signed [25:0] z_coord
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("vertex beat dropped during stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(x_coord) && $stable(y_coord) && $stable(z_coord))
        else $error("vertex beat changed during stall");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("point side stalled with empty output");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (x_coord <= 26'sd16777216 && x_coord >= -26'sd16777216
                    && y_coord <= 26'sd16777216 && y_coord >= -26'sd16777216
                    && z_coord <= 26'sd16777216 && z_coord >= -26'sd16777216))
        else $error("vertex coordinate beyond radius range");

endmodule

bind superquadric_point_eval sqpe_checker u_sqpe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (point.ready),
    .out_valid (vertex.valid),
    .out_ready (vertex.ready),
    .x_coord   (vertex.x_coord),
    .y_coord   (vertex.y_coord),
    .z_coord   (vertex.z_coord)
);
